FILE: rtl/utf16_to_utf8_transcoder_macros.svh
// assertion helpers for the utf-16 to utf-8 transcoder
// both expect clk and rst_n in the scope of use
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// same-cycle implication
`define U8T_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// next-cycle implication
`define U8T_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

FILE: rtl/u8t_pkg.sv
// ----------------------------------------------------------------------------
// u8t_pkg
// Types, constants and the code point encoder of the utf-16 to utf-8 block.
// ----------------------------------------------------------------------------
package u8t_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PointW = 21;
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned LenW   = 3;

  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;
  localparam logic [PointW-1:0] SuppBase = 21'h10000;
  localparam logic [PointW-1:0] MaxOne   = 21'h7f;
  localparam logic [PointW-1:0] MaxTwo   = 21'h7ff;
  localparam logic [PointW-1:0] MaxThree = 21'hffff;
  localparam logic [ByteW-1:0] LeadTwo   = 8'hc0;
  localparam logic [ByteW-1:0] LeadThree = 8'he0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hf0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;
  // lead byte of any surrogate's 3-byte form, and its second byte base
  localparam logic [ByteW-1:0] SurrLead  = 8'hed;
  localparam logic [ByteW-1:0] HighSecond = 8'ha0;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic [3:0][ByteW-1:0] bytes;
    logic [LenW-1:0]       len;
  } enc_t;

  function automatic enc_t encode_point(input logic [PointW-1:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp <= MaxOne) begin
      e.bytes[0] = cp[7:0];
      e.len = 3'd1;
    end else if (cp <= MaxTwo) begin
      e.bytes[0] = LeadTwo | {3'b000, cp[10:6]};
      e.bytes[1] = ContMark | {2'b00, cp[5:0]};
      e.len = 3'd2;
    end else if (cp <= MaxThree) begin
      e.bytes[0] = LeadThree | {4'b0000, cp[15:12]};
      e.bytes[1] = ContMark | {2'b00, cp[11:6]};
      e.bytes[2] = ContMark | {2'b00, cp[5:0]};
      e.len = 3'd3;
    end else begin
      e.bytes[0] = LeadFour | {5'b00000, cp[20:18]};
      e.bytes[1] = ContMark | {2'b00, cp[17:12]};
      e.bytes[2] = ContMark | {2'b00, cp[11:6]};
      e.bytes[3] = ContMark | {2'b00, cp[5:0]};
      e.len = 3'd4;
    end
    return e;
  endfunction

endpackage

FILE: rtl/u8t_in_if.sv
// ----------------------------------------------------------------------------
// u8t_in_if
// Valid/ready channel carrying one utf-16 code unit and its end-of-text flag.
// ----------------------------------------------------------------------------
interface u8t_in_if;
  logic                         valid;
  logic                         ready;
  logic [u8t_pkg::UnitW-1:0]    code_unit;
  logic                         end_of_text;

  modport source (output valid, output code_unit, output end_of_text, input ready);
  modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

FILE: rtl/u8t_out_if.sv
// ----------------------------------------------------------------------------
// u8t_out_if
// Valid/ready channel carrying one utf-8 byte and its end-of-run mark.
// ----------------------------------------------------------------------------
interface u8t_out_if;
  logic                         valid;
  logic                         ready;
  logic [u8t_pkg::ByteW-1:0]    out_byte;
  logic                         run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of utf-16 code units into utf-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one code unit per transfer with an end-of-text flag.
//   out_ch carries one utf-8 byte per transfer; run_last marks the final
//   byte caused by one input unit.
//   A high surrogate that is not the last unit is held and gives no byte;
//   the next unit either completes a 4-byte pair or flushes it as 3 bytes.
// Timing:
//   an accepted unit is encoded into a registered byte buffer of up to
//   six entries; its first byte then moves to the output register and
//   is offered on out_ch from there. The output register drains the buffer
//   at one byte a cycle while out_ch is not stalled; a flushed surrogate
//   plus a 3-byte unit fills up to six bytes.
//   The next unit is taken in the cycle the buffer's last byte moves on.
// Reset: rst_n low clears the held surrogate, the buffer and out_ch.valid.
// Stall: while out_ch.valid is high and out_ch.ready is low the output byte
//   holds, the buffer stops draining and in_ch.ready drops once the buffer is not empty.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic          clk,
  input  logic          rst_n,
  u8t_in_if.sink        in_ch,
  u8t_out_if.source     out_ch
);

  localparam int unsigned ByteW = u8t_pkg::ByteW;

  logic                                   held_valid_r, held_valid_nxt;
  logic [9:0]                             held_bits_r, held_bits_nxt;
  logic [u8t_pkg::MaxBytes-1:0][ByteW-1:0] job_r, job_nxt, job_new;
  logic [u8t_pkg::LenW-1:0]               cnt_r, cnt_nxt, len_new;
  logic                                   out_valid_r, out_valid_nxt;
  logic [ByteW-1:0]                       out_byte_r, out_byte_nxt;
  logic                                   run_last_r, run_last_nxt;

  logic          out_load, accept, is_high, is_low, hold_new;
  u8t_pkg::enc_t enc_unit, enc_pair;
  logic [u8t_pkg::PointW-1:0] pair_cp;

  assign out_load = (cnt_r != '0) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (cnt_r == '0) || ((cnt_r == u8t_pkg::LenW'(1)) && out_load);
  assign accept = in_ch.valid && in_ch.ready;

  assign is_high  = in_ch.code_unit[15:10] == u8t_pkg::HighTag;
  assign is_low   = in_ch.code_unit[15:10] == u8t_pkg::LowTag;
  assign hold_new = is_high && !in_ch.end_of_text;

  assign pair_cp  = u8t_pkg::SuppBase + {1'b0, held_bits_r, 10'b0}
                  + {11'b0, in_ch.code_unit[9:0]};
  assign enc_unit = u8t_pkg::encode_point({5'b0, in_ch.code_unit});
  assign enc_pair = u8t_pkg::encode_point(pair_cp);

  // byte list for the unit on the input channel
  always_comb begin
    job_new = '0;
    len_new = '0;
    if (held_valid_r && is_low) begin
      job_new[3:0] = enc_pair.bytes;
      len_new      = enc_pair.len;
    end else begin
      if (held_valid_r) begin
        // flush the held surrogate as its own 3-byte form
        job_new[0] = u8t_pkg::SurrLead;
        job_new[1] = u8t_pkg::HighSecond | {4'b0000, held_bits_r[9:6]};
        job_new[2] = u8t_pkg::ContMark | {2'b00, held_bits_r[5:0]};
        len_new    = u8t_pkg::LenW'(3);
        if (!hold_new) begin
          job_new[5:3] = enc_unit.bytes[2:0];
          len_new      = u8t_pkg::LenW'(3) + enc_unit.len;
        end
      end else if (!hold_new) begin
        job_new[3:0] = enc_unit.bytes;
        len_new      = enc_unit.len;
      end
    end
  end

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    job_nxt        = job_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    run_last_nxt   = run_last_r;

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = job_r[0];
      run_last_nxt  = cnt_r == u8t_pkg::LenW'(1);
      job_nxt       = job_r >> ByteW;
      cnt_nxt       = cnt_r - u8t_pkg::LenW'(1);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      job_nxt        = job_new;
      cnt_nxt        = len_new;
      held_valid_nxt = hold_new;
      held_bits_nxt  = hold_new ? in_ch.code_unit[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    run_last_r <= run_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = run_last_r;

endmodule

FILE: rtl/u8t_checker.sv
// ----------------------------------------------------------------------------
// u8t_checker
// Port-level checks on the output side of the utf-16 to utf-8 transcoder.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_macros.svh"

module u8t_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last
);

  // a stalled byte holds
  `U8T_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last))

  // an ascii byte always closes its run
  `U8T_ASSERT_NOW(a_ascii_last, out_valid && !out_byte[7], run_last)

  // a lead byte is never the final byte of a run
  `U8T_ASSERT_NOW(a_lead_not_last, out_valid && (out_byte[7:6] == 2'b11), !run_last)

endmodule

bind utf16_to_utf8_transcoder u8t_checker u_u8t_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_last  (out_ch.run_last)
);
